### rtl/qsf_pkg.sv
// Shared types and constants for the quadratic smoothing filter.
// No dependencies; imported by every module of the filter.
`default_nettype none

package qsf_pkg;

    // Sample and result width, two's complement.
    localparam int SAMPLE_W   = 24;
    // Quotient bits produced by the serial divider.
    localparam int QUOT_W     = 24;
    localparam int QUOT_CNT_W = 5;
    // Output clipping limits (magnitudes).
    localparam logic [QUOT_W-1:0] POS_LIMIT = 24'h7FFFFF;
    localparam logic [QUOT_W-1:0] NEG_LIMIT = 24'h800000;

    // One finished result as it leaves the divider.
    typedef struct packed {
        logic                sat;
        logic [SAMPLE_W-1:0] value;
    } qsf_result_t;

endpackage

`default_nettype wire

### rtl/qsf_hist_mem.sv
// Sample history RAM: one write port, one registered read port.
// Depends on qsf_pkg for the sample width.
`default_nettype none

module qsf_hist_mem #(
    parameter int DEPTH = 15,
    parameter int AW    = 4
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [qsf_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output logic      [qsf_pkg::SAMPLE_W-1:0] rd_data
);
    import qsf_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];

    // Writes and reads never target the same cycle: the sequencer writes
    // on accept and reads only in later cycles.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/qsf_divider.sv
// Serial restoring divider with round-half-away, sign restore and clipping.
// Depends on qsf_pkg for widths, limits and the result struct.
`default_nettype none

module qsf_divider #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic             neg,
    input  wire logic [NUM_W-1:0] mag,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output qsf_pkg::qsf_result_t  result
);
    import qsf_pkg::*;

    localparam int RW = DEN_W + QUOT_W + 1;
    localparam int CW = (NUM_W + 1 > DEN_W + QUOT_W) ? NUM_W + 1 : DEN_W + QUOT_W;

    logic [NUM_W:0]          num;
    logic [RW-1:0]           dsh;
    logic [RW-1:0]           rem_reg;
    logic [QUOT_W-1:0]       q_reg;
    logic [QUOT_W-1:0]       q_next;
    logic [QUOT_CNT_W-1:0]   cnt_reg;
    logic                    busy_reg;
    logic                    ovf_reg;
    logic                    neg_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    ge;
    logic                    done_reg;
    qsf_result_t             result_reg;
    qsf_result_t             result_next;

    // Bias by half the divisor so truncation rounds to nearest.
    assign num    = (NUM_W + 1)'(mag) + (NUM_W + 1)'(den >> 1);
    assign dsh    = RW'(den_reg) << (QUOT_W - 1);
    assign ge     = rem_reg >= dsh;
    assign q_next = {q_reg[QUOT_W-2:0], ge};

    always_comb begin
        result_next.sat   = 1'b0;
        result_next.value = q_next;
        if (neg_reg) begin
            if (ovf_reg || q_next > NEG_LIMIT) begin
                result_next.sat   = 1'b1;
                result_next.value = NEG_LIMIT;
            end else begin
                result_next.value = SAMPLE_W'(-q_next);
            end
        end else if (ovf_reg || q_next > POS_LIMIT) begin
            result_next.sat   = 1'b1;
            result_next.value = POS_LIMIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                done_reg <= 1'b0;
            end else if (busy_reg) begin
                cnt_reg  <= cnt_reg + 1'b1;
                busy_reg <= (cnt_reg != QUOT_CNT_W'(QUOT_W - 1));
                done_reg <= (cnt_reg == QUOT_CNT_W'(QUOT_W - 1));
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= RW'(num);
            q_reg   <= '0;
            den_reg <= den;
            neg_reg <= neg;
            // Quotient would need more than QUOT_W bits: clip regardless.
            ovf_reg <= CW'(num) >= (CW'(den) << QUOT_W);
        end else if (busy_reg) begin
            rem_reg <= (ge ? (rem_reg - dsh) : rem_reg) << 1;
            q_reg   <= q_next;
            if (cnt_reg == QUOT_CNT_W'(QUOT_W - 1)) begin
                result_reg <= result_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/quadratic_smoothing_filter.sv
// Quadratic smoothing filter, top level: sequencer, MAC and stream ports.
// Depends on qsf_pkg, qsf_hist_mem and qsf_divider.
`default_nettype none

// Savitzky-Golay quadratic smoother over the last W samples (W odd, 3..15,
// from the window_length register; even values round down, values below
// three act as three, values above MAX_WINDOW clamp). Each accepted beat
// is written into a circular history RAM. Once W samples have arrived,
// each beat yields one result: the fitted quadratic at the window centre,
// lagging the input by (W-1)/2 samples, rounded half away from zero and
// clipped to 24 bits with the clip reported in m_tuser. Beats that arrive
// while the window is still filling produce no result and leave the
// sequencer idle for the next beat. A beat that produces a result passes
// through the setup states S_SETUP1 and S_SETUP2, which derive the fit
// constants, then one RAM read per tap feeding the multiply-accumulate
// through the product and accumulate registers, then the serial divider,
// one quotient bit at a time, and then S_OUT, which loads the output
// register once it is free. A result still waiting in the output register
// holds the sequencer until it is taken. One beat is processed at a time;
// a finished result waits in the output register while the next beat is
// taken. Window changes apply from the next beat on and keep the history.
module quadratic_smoothing_filter #(
    parameter int MAX_WINDOW = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration: window_length.
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [23:0] sample
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [23:0] smoothed
    output logic [0:0]       m_tuser    // [0] saturated
);
    import qsf_pkg::*;

    localparam int AW      = $clog2(MAX_WINDOW);
    localparam int FW      = $clog2(MAX_WINDOW + 1);
    localparam int MAX_ODD = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
    localparam int BW      = 2 * AW + 4;       // base weight, unsigned
    localparam int WW      = 2 * AW + 5;       // tap weight, signed
    localparam int PW      = SAMPLE_W + WW;    // one product
    localparam int ACCW    = PW + AW;          // sum over the window
    localparam int DEN_W   = 3 * AW + 4;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SETUP1 = 6'b000010,
        S_SETUP2 = 6'b000100,
        S_MAC    = 6'b001000,
        S_DIV    = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [3:0]            win_reg;
    logic [3:0]            w_eff;
    logic [3:0]            w_reg;
    logic [AW-1:0]         m_reg;
    logic [FW-1:0]         fill_reg, fill_next;
    logic [AW-1:0]         wp_reg;
    logic [AW-1:0]         newest_reg;
    logic [2*AW-1:0]       msq_reg;
    logic [BW-1:0]         base_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [AW-1:0]         k_reg;
    logic                  iss_reg;
    logic                  v1_reg, v2_reg;
    logic signed [WW-1:0]  wt_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic                  accept;
    logic [AW-1:0]         rd_addr;
    logic [SAMPLE_W-1:0]   rd_data;
    logic signed [AW:0]    tap_off;
    logic [AW-1:0]         tap_abs;
    logic [2*AW-1:0]       isq;
    logic [BW-1:0]         isq15;
    logic                  mac_done;
    logic                  div_start;
    logic [ACCW-1:0]       acc_mag;
    logic                  div_done;
    qsf_result_t           div_result;
    logic                  out_free;
    logic                  m_tvalid_reg;
    qsf_result_t           m_result_reg;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // Effective odd window length.
    always_comb begin
        w_eff = win_reg;
        if (w_eff < 4'd3) begin
            w_eff = 4'd3;
        end
        if (!w_eff[0]) begin
            w_eff = w_eff - 4'd1;
        end
        if (32'(w_eff) > MAX_WINDOW) begin
            w_eff = 4'(MAX_ODD);
        end
    end

    assign fill_next = (fill_reg == FW'(MAX_WINDOW)) ? fill_reg : fill_reg + 1'b1;

    // Tap k sits k samples behind the newest one in the circular buffer.
    assign rd_addr = (k_reg > newest_reg) ? newest_reg + AW'(MAX_WINDOW) - k_reg
                                          : newest_reg - k_reg;

    // Tap weight: base - 15 * (k - m)^2.
    assign tap_off = $signed({1'b0, k_reg}) - $signed({1'b0, m_reg});
    assign tap_abs = tap_off[AW] ? AW'(-tap_off) : AW'(tap_off);
    assign isq     = tap_abs * tap_abs;
    assign isq15   = (BW'(isq) << 4) - BW'(isq);

    assign mac_done  = !iss_reg && !v1_reg && !v2_reg;
    assign div_start = (state_reg == S_MAC) && mac_done;
    assign acc_mag   = acc_reg[ACCW-1] ? ACCW'(-acc_reg) : ACCW'(acc_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && (32'(fill_next) >= 32'(w_eff))) begin
                    state_next = S_SETUP1;
                end
            end
            S_SETUP1: state_next = S_SETUP2;
            S_SETUP2: state_next = S_MAC;
            S_MAC: begin
                if (mac_done) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            win_reg      <= 4'd7;
            fill_reg     <= '0;
            wp_reg       <= '0;
            iss_reg      <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                win_reg <= cfg_wdata;
            end
            if (accept) begin
                fill_reg <= fill_next;
                wp_reg   <= (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
            end
            // Issue one tap read per cycle, stop after the last tap.
            if (state_reg == S_SETUP2) begin
                iss_reg <= 1'b1;
            end else if (iss_reg && (32'(k_reg) == 32'(w_reg) - 1)) begin
                iss_reg <= 1'b0;
            end
            v1_reg <= iss_reg;
            v2_reg <= v1_reg;
            // Drop the result once taken, load a new one when free.
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            newest_reg <= wp_reg;
            w_reg      <= w_eff;
            m_reg      <= AW'(w_eff >> 1);
        end
        if (state_reg == S_SETUP1) begin
            msq_reg <= m_reg * m_reg;
        end
        if (state_reg == S_SETUP2) begin
            // base = 9m^2 + 9m - 3, den = (4m^2 - 1)(2m + 3)
            base_reg <= (BW'(msq_reg) << 3) + BW'(msq_reg)
                      + (BW'(m_reg) << 3) + BW'(m_reg) - BW'(3);
            den_reg  <= DEN_W'(((DEN_W'(msq_reg) << 2) - DEN_W'(1))
                      * ((DEN_W'(m_reg) << 1) + DEN_W'(3)));
            k_reg    <= '0;
            acc_reg  <= '0;
        end
        if (iss_reg) begin
            k_reg  <= k_reg + 1'b1;
            wt_reg <= $signed(WW'(base_reg)) - $signed(WW'(isq15));
        end
        if (v1_reg) begin
            prod_reg <= $signed(rd_data) * wt_reg;
        end
        if (v2_reg) begin
            acc_reg <= acc_reg + ACCW'(prod_reg);
        end
        if (state_reg == S_OUT && out_free) begin
            m_result_reg <= div_result;
        end
    end

    qsf_hist_mem #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (s_tdata),
        .rd_en   (iss_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    qsf_divider #(
        .NUM_W (ACCW),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .neg     (acc_reg[ACCW-1]),
        .mag     (acc_mag),
        .den     (den_reg),
        .done    (div_done),
        .result  (div_result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_result_reg.value;
    assign m_tuser  = m_result_reg.sat;

endmodule

`default_nettype wire

### test/quadratic_smoothing_filter_tb.sv
// Self-checking testbench for quadratic_smoothing_filter: directed window and
// clipping cases, then random windows and samples under random stalls.
// Depends on qsf_pkg and the filter RTL.
`timescale 1ns / 100ps

module quadratic_smoothing_filter_tb;

    import qsf_pkg::*;

    localparam int MAX_TAPS      = 15;
    localparam int DRAIN_CYCLES  = 64;    // covers the processing of one beat
    localparam int STALL_LIMIT   = 4000;  // cycles with no beat on either side
    localparam int RANDOM_PHASES = 24;

    localparam logic [23:0] SMP_MAX  = 24'h7FFFFF;
    localparam logic [23:0] SMP_MIN  = 24'h800000;
    localparam logic [23:0] SMP_ZERO = 24'h000000;
    localparam logic [23:0] SMP_NEG1 = 24'hFFFFFF;
    localparam logic [23:0] SMP_POS1 = 24'h000001;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = 24'd0;   // [23:0] sample
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;             // [23:0] smoothed
    logic [0:0]  m_tuser;             // [0] saturated

    quadratic_smoothing_filter #(
        .MAX_WINDOW(MAX_TAPS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Filter state as the predictor sees it.
    logic signed [23:0] range_hist [MAX_TAPS];
    int unsigned        fill_cnt   = 0;
    logic [3:0]         window_reg = 4'd7;

    // Fitted values still owed by the filter, oldest first.
    qsf_result_t smooth_q [$];

    int err_count   = 0;
    bit no_idle     = 1'b0;   // set for stretches of back-to-back beats
    int range_level = 0;      // slowly drifting range for realistic samples
    int rdy_stall   = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Gap lengths: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 50);
    endfunction

    // Effective odd window: lift below three, round even down, clamp at the top.
    function automatic int unsigned fit_window(input logic [3:0] req);
        int unsigned w;
        w = req;
        if (w < 3)
            w = 3;
        if ((w & 1) == 0)
            w = w - 1;
        if (w > MAX_TAPS) begin
            w = MAX_TAPS;
            if ((w & 1) == 0)
                w = w - 1;
        end
        return w;
    endfunction

    // Shift one sample into the history and queue the fitted centre value
    // once the window is full.
    task automatic predict_smoothed(input logic [23:0] smp);
        int unsigned       w;
        longint            m, base_wt, den, acc, tap_ofs, wt;
        longint unsigned   mag, q;
        bit                neg;
        qsf_result_t       res;
        for (int k = MAX_TAPS - 1; k > 0; k--)
            range_hist[k] = range_hist[k-1];
        range_hist[0] = smp;
        if (fill_cnt < MAX_TAPS)
            fill_cnt++;
        w = fit_window(window_reg);
        if (fill_cnt < w)
            return;
        m       = (w - 1) / 2;
        base_wt = 3 * (3 * m * m + 3 * m - 1);
        den     = (2 * m - 1) * (2 * m + 1) * (2 * m + 3);
        acc     = 0;
        for (int k = 0; k < w; k++) begin
            tap_ofs = k - m;
            wt      = base_wt - 15 * tap_ofs * tap_ofs;
            acc     = acc + wt * longint'(range_hist[k]);
        end
        // Round the magnitude half up, i.e. ties away from zero.
        neg = acc < 0;
        mag = neg ? longint'(-acc) : longint'(acc);
        q   = (mag + den / 2) / den;
        res.sat = 1'b0;
        if (neg) begin
            if (q > 64'h800000) begin
                q       = 64'h800000;
                res.sat = 1'b1;
            end
            res.value = 24'(-longint'(q));
        end else begin
            if (q > 64'h7FFFFF) begin
                q       = 64'h7FFFFF;
                res.sat = 1'b1;
            end
            res.value = 24'(q);
        end
        smooth_q.push_back(res);
    endtask

    // Send one beat after a random gap; keep tvalid high into the next beat
    // when there is no gap, so it is never lowered and raised in one step.
    task automatic send_sample(input logic [23:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_smoothed(smp);
    endtask

    // Drop tvalid, hold until every owed result is back, then let a beat
    // that produces no result finish too.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (smooth_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Only called with the filter idle.
    task automatic write_window_length(input logic [3:0] len);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        window_reg  = len;
    endtask

    // Mix of full-range noise, extremes, a drifting range and near-rail swings.
    function automatic logic [23:0] random_sample();
        int          r;
        logic [31:0] raw;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            raw = $urandom();
            return raw[23:0];
        end
        if (r < 40) begin
            case ($urandom_range(0, 4))
                0: return SMP_MAX;
                1: return SMP_MIN;
                2: return SMP_ZERO;
                3: return SMP_NEG1;
                default: return SMP_POS1;
            endcase
        end
        if (r < 75) begin
            range_level = range_level + int'($urandom_range(0, 2000)) - 1000;
            if (range_level > 4000000)
                range_level = 4000000;
            if (range_level < -4000000)
                range_level = -4000000;
            return 24'(range_level + int'($urandom_range(0, 64)) - 32);
        end
        if ($urandom_range(0, 1) == 1)
            return SMP_MAX - 24'($urandom_range(0, 1000));
        return SMP_MIN + 24'($urandom_range(0, 1000));
    endfunction

    // Default window of seven: six filling beats, then the first result.
    task automatic test_fill_default_window();
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(SMP_ZERO);
        send_sample(SMP_NEG1);
        send_sample(SMP_POS1);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        wait_drained();
    endtask

    // Grow to the widest window with history kept: eight more beats fill it.
    task automatic test_window_growth();
        write_window_length(4'd15);
        for (int k = 0; k < 8; k++)
            send_sample((k % 2 == 0) ? SMP_MAX - 24'(k) : SMP_MIN + 24'(k));
        wait_drained();
    endtask

    // Edge taps carry negative weight: rails on the edges against the
    // opposite rail inside drive the fit past both limits.
    task automatic test_clip_extremes();
        write_window_length(4'd5);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        send_sample(SMP_MAX);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        send_sample(SMP_MIN);
        send_sample(SMP_MIN);
        send_sample(SMP_MIN);
        send_sample(SMP_MAX);
        wait_drained();
    endtask

    // Walk every register value, then random ones; each phase starts idle,
    // which also holds the sender until all results are back.
    task automatic test_random_windows();
        int       n_items;
        logic [3:0] len;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            len     = (p < 16) ? 4'((p * 7) % 16) : 4'($urandom_range(0, 15));
            no_idle = ($urandom_range(0, 4) == 0);
            write_window_length(len);
            n_items = $urandom_range(35, 75);
            for (int k = 0; k < n_items; k++)
                send_sample(random_sample());
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    // Receiver: random stalls on m_tready, one assignment per edge.
    always @(posedge aclk) begin
        int gap;
        if (rdy_stall > 0) begin
            rdy_stall <= rdy_stall - 1;
            m_tready  <= 1'b0;
        end else begin
            gap        = pick_gap();
            rdy_stall <= (gap > 0) ? gap - 1 : 0;
            m_tready  <= (gap == 0);
        end
    end

    // Compare each result beat with the oldest owed value.
    always @(posedge aclk) begin
        qsf_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (smooth_q.size() == 0) begin
                $display("%0t: unexpected result: smoothed %0d saturated %0b",
                         $time, $signed(m_tdata), m_tuser[0]);
                err_count++;
            end else begin
                exp_r = smooth_q.pop_front();
                if (m_tdata !== exp_r.value) begin
                    $display("%0t: smoothed mismatch: expected %0d actual %0d",
                             $time, $signed(exp_r.value), $signed(m_tdata));
                    err_count++;
                end
                if (m_tuser[0] !== exp_r.sat) begin
                    $display("%0t: saturated mismatch: expected %0b actual %0b",
                             $time, exp_r.sat, m_tuser[0]);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, no beat for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        for (int k = 0; k < MAX_TAPS; k++)
            range_hist[k] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_default_window();
        test_window_growth();
        test_clip_extremes();
        test_random_windows();

        wait_drained();
        if (err_count == 0 && smooth_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/qsf_pkg.sv
rtl/qsf_hist_mem.sv
rtl/qsf_divider.sv
rtl/quadratic_smoothing_filter.sv
test/quadratic_smoothing_filter_tb.sv
